FILE: rtl/core/gbe_pkg.sv
package gbe_pkg;

    localparam int CAPACITY   = 1024;
    localparam int ITEM_WIDTH = 8;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 8;
    localparam int POS_W    = 11;
    localparam int OUT_W    = 11;
    localparam int STATUS_W = 2;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int CALC_W = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 2'd0,
        K_DELETE = 2'd1,
        K_MOVE   = 2'd2,
        K_READ   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MV_RD,
        S_MV_WR
    } t_state;

endpackage

FILE: rtl/core/gbe_ram.sv
module gbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/gap_buffer_engine.sv
// Gap buffer over a single simple dual-port item store with registered read.
// A transaction is taken when start is high and busy is low; its result is
// shown on the o_ ports for exactly one cycle, marked by o_done, and cannot
// be held off. Insert, delete, a refused request and a move to the current
// gap position give their result in the cycle after acceptance, and the next
// transaction can be taken in that same cycle.
// A read inside the contents waits in S_READ for the store's registered read.
// A move steps through S_MV_RD then S_MV_WR for each item crossing the gap,
// as each item is read then written back through the one store. No clearing
// pass follows reset; requests are taken in the first cycle after it.
module gap_buffer_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [gbe_pkg::KIND_W-1:0]       i_kind,
    input  logic [gbe_pkg::VALUE_W-1:0]      i_item_value,
    input  logic [gbe_pkg::POS_W-1:0]        i_position,
    input  logic [gbe_pkg::POS_W-1:0]        i_count,
    output logic                             o_done,
    output logic [gbe_pkg::VALUE_W-1:0]      o_read_value,
    output logic [gbe_pkg::OUT_W-1:0]        o_item_count,
    output logic [gbe_pkg::OUT_W-1:0]        o_gap_start,
    output logic [gbe_pkg::STATUS_W-1:0]     o_status
);

    import gbe_pkg::*;

    t_state                r_state, n_state;
    logic [PTR_W-1:0]      r_gap_low, n_gap_low;
    logic [PTR_W-1:0]      r_gap_high, n_gap_high;
    logic [PTR_W-1:0]      r_target, n_target;
    logic                  r_left, n_left;
    logic                  r_done, n_done;
    t_status               r_status, n_status;
    logic [ITEM_WIDTH-1:0] r_read_value, n_read_value;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    logic                  accept;
    t_kind                 kind;
    logic [PTR_W-1:0]      items;
    logic [CALC_W-1:0]     pos_ext;
    logic [PTR_W-1:0]      target;
    logic [CALC_W-1:0]     phys;
    logic                  move_last;

    gbe_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept  = start && (r_state == S_IDLE);
    assign kind    = t_kind'(i_kind);
    assign items   = r_gap_low + (PTR_W'(CAPACITY) - r_gap_high);
    assign pos_ext = CALC_W'(i_position);
    assign target  = (pos_ext > CALC_W'(items)) ? items : PTR_W'(i_position);
    assign phys    = (pos_ext < CALC_W'(r_gap_low)) ? pos_ext
                   : pos_ext + CALC_W'(r_gap_high - r_gap_low);
    assign move_last = r_left ? ((r_gap_low - 1'b1) == r_target)
                              : ((r_gap_low + 1'b1) == r_target);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (kind == K_READ && CALC_W'(i_position) < CALC_W'(items)) begin
                        n_state = S_READ;
                    end else if (kind == K_MOVE && target != r_gap_low) begin
                        n_state = S_MV_RD;
                    end
                end
            end
            S_READ:  n_state = S_IDLE;
            S_MV_RD: n_state = S_MV_WR;
            S_MV_WR: n_state = move_last ? S_IDLE : S_MV_RD;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_gap_low    = r_gap_low;
        n_gap_high   = r_gap_high;
        n_target     = r_target;
        n_left       = r_left;
        n_done       = 1'b0;
        n_status     = r_status;
        n_read_value = r_read_value;
        ram_we       = 1'b0;
        ram_waddr    = r_gap_low[ADDR_W-1:0];
        ram_wdata    = ram_rdata;
        ram_raddr    = phys[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status     = ST_DONE;
                    n_read_value = '0;
                    n_target     = target;
                    n_left       = (target < r_gap_low);
                    unique case (kind)
                        K_INSERT: begin
                            n_done = 1'b1;
                            if (r_gap_low == r_gap_high) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = i_item_value[ITEM_WIDTH-1:0];
                                n_gap_low = r_gap_low + 1'b1;
                            end
                        end
                        K_DELETE: begin
                            n_done = 1'b1;
                            if (CALC_W'(i_count) > CALC_W'(r_gap_low)) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_gap_low = r_gap_low - PTR_W'(i_count);
                            end
                        end
                        K_MOVE: begin
                            n_done = (target == r_gap_low);
                        end
                        K_READ: begin
                            if (pos_ext >= CALC_W'(items)) begin
                                n_done   = 1'b1;
                                n_status = ST_RANGE;
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_READ: begin
                n_done       = 1'b1;
                n_read_value = ram_rdata;
            end
            S_MV_RD: begin
                ram_raddr = r_left ? ADDR_W'(r_gap_low - 1'b1) : r_gap_high[ADDR_W-1:0];
            end
            S_MV_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_left ? ADDR_W'(r_gap_high - 1'b1) : r_gap_low[ADDR_W-1:0];
                if (r_left) begin
                    n_gap_low  = r_gap_low - 1'b1;
                    n_gap_high = r_gap_high - 1'b1;
                end else begin
                    n_gap_low  = r_gap_low + 1'b1;
                    n_gap_high = r_gap_high + 1'b1;
                end
                n_done = move_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_gap_low  <= '0;
            r_gap_high <= PTR_W'(CAPACITY);
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_gap_low  <= n_gap_low;
            r_gap_high <= n_gap_high;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target     <= n_target;
        r_left       <= n_left;
        r_status     <= n_status;
        r_read_value <= n_read_value;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_read_value = VALUE_W'(r_read_value);
    assign o_item_count = OUT_W'(items);
    assign o_gap_start  = OUT_W'(r_gap_low);
    assign o_status     = r_status;

    a_gap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gap_low <= r_gap_high) && (r_gap_high <= PTR_W'(CAPACITY)))
        else $error("gap pointers out of order");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !busy)
        else $error("result strobe while busy");

    a_read_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> r_done)
        else $error("read result not delivered");

    a_move_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MV_WR) |=> (r_gap_low != $past(r_gap_low)))
        else $error("gap did not advance on move");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import gbe_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd4 * 1600 * (2 * CAPACITY + 40);

    typedef struct {
        t_kind                kind;
        logic [VALUE_W-1:0]   value;
        logic [POS_W-1:0]     pos;
        logic [POS_W-1:0]     cnt;
    } t_gap_op;

    typedef struct {
        logic [VALUE_W-1:0]   read_value;
        logic [OUT_W-1:0]     item_count;
        logic [OUT_W-1:0]     gap_start;
        t_status              status;
    } t_gap_reply;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind = '0;
    logic [VALUE_W-1:0]   i_item_value = '0;
    logic [POS_W-1:0]     i_position = '0;
    logic [POS_W-1:0]     i_count = '0;
    logic                 o_done;
    logic [VALUE_W-1:0]   o_read_value;
    logic [OUT_W-1:0]     o_item_count;
    logic [OUT_W-1:0]     o_gap_start;
    logic [STATUS_W-1:0]  o_status;

    gap_buffer_engine uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_item_value (i_item_value),
        .i_position   (i_position),
        .i_count      (i_count),
        .o_done       (o_done),
        .o_read_value (o_read_value),
        .o_item_count (o_item_count),
        .o_gap_start  (o_gap_start),
        .o_status     (o_status)
    );

    t_gap_op     pending_ops[$];
    t_gap_reply  expected_replies[$];
    t_gap_op     op_in_flight;
    t_gap_reply  predicted;
    t_gap_reply  oldest;

    // predictor state
    logic [VALUE_W-1:0] item_mem [CAPACITY];
    int gap_lo = 0;
    int gap_hi = CAPACITY;

    // stimulus planning shadow (counts only)
    int plan_count = 0;
    int plan_gap = 0;

    int     sender_idle_pct = 0;
    int     errors = 0;
    longint cycles = 0;
    int     n_insert = 0, n_full = 0, n_delete = 0, n_move = 0, n_read = 0;
    int     n_refused = 0, moved_items = 0, peak_fill = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic apply_request(input t_gap_op op, output t_gap_reply rep);
        int n;
        int target;
        int phys;
        n = gap_lo + CAPACITY - gap_hi;
        rep.read_value = '0;
        rep.status = ST_DONE;
        case (op.kind)
            K_INSERT: begin
                n_insert++;
                if (gap_lo >= gap_hi) begin
                    rep.status = ST_FULL;
                    n_full++;
                end else begin
                    item_mem[gap_lo] = op.value;
                    gap_lo++;
                end
            end
            K_DELETE: begin
                n_delete++;
                if (int'(op.cnt) > gap_lo) begin
                    rep.status = ST_RANGE;
                    n_refused++;
                end else begin
                    gap_lo -= int'(op.cnt);
                end
            end
            K_MOVE: begin
                n_move++;
                target = (int'(op.pos) > n) ? n : int'(op.pos);
                while (gap_lo > target) begin
                    gap_lo--;
                    gap_hi--;
                    item_mem[gap_hi] = item_mem[gap_lo];
                    moved_items++;
                end
                while (gap_lo < target) begin
                    item_mem[gap_lo] = item_mem[gap_hi];
                    gap_lo++;
                    gap_hi++;
                    moved_items++;
                end
            end
            K_READ: begin
                n_read++;
                if (int'(op.pos) >= n) begin
                    rep.status = ST_RANGE;
                    n_refused++;
                end else begin
                    phys = (int'(op.pos) < gap_lo) ? int'(op.pos)
                                                  : int'(op.pos) + gap_hi - gap_lo;
                    rep.read_value = item_mem[phys];
                end
            end
            default: ;
        endcase
        rep.item_count = OUT_W'(gap_lo + CAPACITY - gap_hi);
        rep.gap_start = OUT_W'(gap_lo);
        if (int'(rep.item_count) > peak_fill) peak_fill = rep.item_count;
    endtask

    task automatic plan_op(input t_kind kind, input int value, input int pos, input int cnt);
        t_gap_op op;
        op.kind = kind;
        op.value = VALUE_W'(value);
        op.pos = POS_W'(pos);
        op.cnt = POS_W'(cnt);
        pending_ops.push_back(op);
        case (kind)
            K_INSERT: begin
                if (plan_count < CAPACITY) begin
                    plan_count++;
                    plan_gap++;
                end
            end
            K_DELETE: begin
                if (cnt <= plan_gap) begin
                    plan_gap -= cnt;
                    plan_count -= cnt;
                end
            end
            K_MOVE: plan_gap = (pos > plan_count) ? plan_count : pos;
            default: ;
        endcase
    endtask

    task automatic plan_random_op(input int w_ins, input int w_del, input int w_mov);
        int pick;
        int sel;
        int arg;
        pick = $urandom_range(99);
        sel = $urandom_range(99);
        if (pick < w_ins) begin
            plan_op(K_INSERT, $urandom_range(255), $urandom_range(2047),
                    $urandom_range(2047));
        end else if (pick < w_ins + w_del) begin
            if (sel < 65)
                arg = $urandom_range((plan_gap < 8) ? plan_gap : 8);
            else if (sel < 75)
                arg = plan_gap;
            else if (sel < 85)
                arg = plan_gap + 1;
            else
                arg = $urandom_range(2047);
            plan_op(K_DELETE, $urandom_range(255), $urandom_range(2047), arg);
        end else if (pick < w_ins + w_del + w_mov) begin
            if (sel < 60) begin
                arg = plan_gap + int'($urandom_range(16)) - 8;
                if (arg < 0) arg = 0;
            end else if (sel < 80) begin
                arg = $urandom_range(plan_count);
            end else if (sel < 90) begin
                arg = plan_count;
            end else begin
                arg = $urandom_range(2047);
            end
            plan_op(K_MOVE, $urandom_range(255), arg, $urandom_range(2047));
        end else begin
            if (sel < 75 && plan_count > 0)
                arg = $urandom_range(plan_count - 1);
            else if (sel < 85)
                arg = plan_count;
            else
                arg = $urandom_range(2047);
            plan_op(K_READ, $urandom_range(255), arg, $urandom_range(2047));
        end
    endtask

    task automatic drain;
        while (pending_ops.size() > 0 || expected_replies.size() > 0 || start)
            @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_request(op_in_flight, predicted);
                expected_replies.push_back(predicted);
            end
            if (!start || !busy) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    op_in_flight = pending_ops.pop_front();
                    start <= 1'b1;
                    i_kind <= op_in_flight.kind;
                    i_item_value <= op_in_flight.value;
                    i_position <= op_in_flight.pos;
                    i_count <= op_in_flight.cnt;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_replies.size() == 0) begin
                $error("result with none outstanding: read_value %0d item_count %0d status %0d",
                       o_read_value, o_item_count, o_status);
                errors++;
            end else begin
                oldest = expected_replies.pop_front();
                if (o_read_value !== oldest.read_value) begin
                    $error("read_value: expected %0d, got %0d", oldest.read_value, o_read_value);
                    errors++;
                end
                if (o_item_count !== oldest.item_count) begin
                    $error("item_count: expected %0d, got %0d", oldest.item_count, o_item_count);
                    errors++;
                end
                if (o_gap_start !== oldest.gap_start) begin
                    $error("gap_start: expected %0d, got %0d", oldest.gap_start, o_gap_start);
                    errors++;
                end
                if (o_status !== oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, small contents, clamping and refusals
        sender_idle_pct = 13;
        plan_op(K_READ,   0, 0,    0);
        plan_op(K_DELETE, 0, 0,    0);
        plan_op(K_DELETE, 0, 0,    1);
        plan_op(K_MOVE,   0, 5,    0);
        plan_op(K_INSERT, 8'h00, 0, 0);
        plan_op(K_INSERT, 8'hFF, 2047, 2047);
        plan_op(K_INSERT, 8'hA5, 0, 0);
        plan_op(K_INSERT, 8'h5A, 0, 0);
        plan_op(K_READ,   0, 0,    0);
        plan_op(K_READ,   0, 3,    0);
        plan_op(K_READ,   0, 4,    0);
        plan_op(K_READ,   0, 2047, 0);
        plan_op(K_MOVE,   0, 1,    0);
        plan_op(K_MOVE,   0, 1,    0);
        plan_op(K_READ,   0, 1,    0);
        plan_op(K_READ,   0, 3,    0);
        plan_op(K_INSERT, 8'h3C, 0, 0);
        plan_op(K_MOVE,   0, 2047, 0);
        plan_op(K_DELETE, 0, 0,    2);
        plan_op(K_DELETE, 0, 0,    1024);
        plan_op(K_DELETE, 0, 0,    2047);
        plan_op(K_MOVE,   0, 0,    0);
        plan_op(K_READ,   0, 0,    0);
        plan_op(K_DELETE, 0, 0,    0);
        plan_op(K_DELETE, 0, 0,    1);
        drain();

        // mixed traffic, contents stay small
        repeat (100) plan_random_op(35, 20, 20);
        drain();

        // fill to capacity, then hammer the full store
        sender_idle_pct = 64;
        while (plan_count < CAPACITY) plan_random_op(95, 0, 3);
        repeat (40) plan_random_op(45, 5, 20);
        drain();

        // back-to-back, including large deletes
        sender_idle_pct = 0;
        repeat (60) plan_random_op(30, 25, 20);
        drain();

        repeat (20) @(posedge i_clk);
        $display("Ran %0d inserts (%0d refused as full), %0d deletes, %0d moves, %0d reads",
                 n_insert, n_full, n_delete, n_move, n_read);
        $display("%0d out-of-range refusals, %0d items shifted across the gap, peak fill %0d",
                 n_refused, moved_items, peak_fill);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
